>>> src/ils_pkg.sv
// Package for the integer list sorter: constants and beat types.
`default_nettype none
package ils_pkg;
  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned Q_DEPTH = 4;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_item;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } out_beat_t;

  // Queue entry between the front and the insertion chain.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    keep;
    logic                    close;
    logic                    ovf;
  } q_ent_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN
  } chain_st_t;
endpackage
`default_nettype wire

>>> src/ils_front.sv
// Front end: counts list entries, flags drops, hands beats to the queue.
`default_nettype none
module ils_front import ils_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     acc,
  input  var  in_beat_t beat,
  output q_ent_t        ent
);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic          room;

  assign room = cnt_r < CW'(MAX_ITEMS);

  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    ent.value = beat.value;
    ent.keep  = room;
    ent.close = beat.last_item;
    ent.ovf   = drop_r | ~room;
    if (acc) begin
      if (room) cnt_nxt = cnt_r + 1'b1;
      else drop_nxt = 1'b1;
      if (beat.last_item) begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end
endmodule
`default_nettype wire

>>> src/ils_queue.sv
// Short FIFO between the front end and the sorting chain.
`default_nettype none
module ils_queue import ils_pkg::*; #(
  parameter int unsigned DEPTH = Q_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  var  q_ent_t din,
  output logic      full,
  output logic      nempty,
  input  wire logic pop,
  output q_ent_t    dout
);
  localparam int unsigned AW = $clog2(DEPTH);
  q_ent_t         mem [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    n_r;

  assign full   = n_r == (AW+1)'(DEPTH);
  assign nempty = n_r != '0;
  assign dout   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      n_r <= n_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> src/ils_chain.sv
// Back end: insertion cell chain that sorts while loading and drains in order.
`default_nettype none
module ils_chain import ils_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic avail,
  input  var  q_ent_t ent,
  output logic      pop,
  output logic      out_valid,
  output out_beat_t out_beat
);
  logic signed [VAL_W-1:0] val_r [MAX_ITEMS];
  logic                    occ_r [MAX_ITEMS];
  logic                    ins   [MAX_ITEMS];
  chain_st_t st_r, st_nxt;
  logic      ovf_r;
  logic      load, shift;

  // Insert after all cells holding values <= new one (stable).
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++)
      ins[i] = ~occ_r[i] | (val_r[i] > ent.value);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD:  if (avail && ent.close) st_nxt = ST_DRAIN;
      ST_DRAIN: if (!occ_r[1]) st_nxt = ST_LOAD;
      default:  st_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    load  = 1'b0;
    shift = 1'b0;
    case (st_r)
      ST_LOAD: begin
        pop  = avail;
        load = avail & ent.keep;
      end
      ST_DRAIN: shift = 1'b1;
      default: ;
    endcase
  end

  assign out_valid             = shift;
  assign out_beat.sorted_value = val_r[0];
  assign out_beat.last_out     = ~occ_r[1];
  assign out_beat.overflow     = ovf_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < MAX_ITEMS-1; i++) val_r[i] <= val_r[i+1];
    end else if (load) begin
      if (ins[0]) val_r[0] <= ent.value;
      for (int i = 1; i < MAX_ITEMS; i++) begin
        if (ins[i]) val_r[i] <= ins[i-1] ? val_r[i-1] : ent.value;
      end
    end
    if (pop && ent.close) ovf_r <= ent.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      for (int i = 0; i < MAX_ITEMS; i++) occ_r[i] <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (shift) begin
        for (int i = 0; i < MAX_ITEMS-1; i++) occ_r[i] <= occ_r[i+1];
        occ_r[MAX_ITEMS-1] <= 1'b0;
      end else if (load) begin
        if (ins[0]) occ_r[0] <= 1'b1;
        for (int i = 1; i < MAX_ITEMS; i++) begin
          if (ins[i]) occ_r[i] <= occ_r[i-1] | ~ins[i-1];
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> src/integer_list_sorter.sv
// Top level of the integer list sorter.
// Accepts one element per cycle (start high, busy low); the beat with last_item
// closes the list. Elements enter a 4-deep queue and then an insertion cell
// chain of MAX_ITEMS cells, which keeps the list sorted (ascending, stable)
// while it loads, one element per cycle. After the closing element reaches the
// chain, the chain drains one result per cycle on out_valid; the receiver cannot
// stall. The closing beat is first written into the queue, then loaded into
// the chain, which then switches to draining; beats still waiting in the queue
// ahead of it are loaded first. busy rises while the queue is full, so a new
// list overlaps the drain of the previous one until the queue fills. Elements
// beyond MAX_ITEMS are dropped and the list's results carry overflow.
`default_nettype none
module integer_list_sorter import ils_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  var  in_beat_t in_beat,
  output logic       out_valid,
  output out_beat_t  out_beat
);
  q_ent_t f_ent, q_ent;
  logic   acc, q_full, q_ne, q_pop;

  // accept an offered beat (start high) whenever the queue has room
  assign busy = q_full;
  assign acc  = start & ~busy;

  ils_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .beat(in_beat), .ent(f_ent)
  );

  ils_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(acc), .din(f_ent), .full(q_full),
    .nempty(q_ne), .pop(q_pop), .dout(q_ent)
  );

  ils_chain #(.MAX_ITEMS(MAX_ITEMS)) u_chain (
    .clk(clk), .rst_n(rst_n), .avail(q_ne), .ent(q_ent), .pop(q_pop),
    .out_valid(out_valid), .out_beat(out_beat)
  );

  // never pop an empty queue
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_ne)
    else $error("pop of empty queue");
  // never accept while the queue is full
  a_acc: assert property (@(posedge clk) disable iff (!rst_n) acc |-> !q_full)
    else $error("accept while full");
  // results stop after the last one of a list
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.last_out) |=> !out_valid)
    else $error("result after last");
endmodule
`default_nettype wire

>>> test/integer_list_sorter_tb.sv
// Testbench for the integer list sorter: directed and random lists, scoreboard check.
`default_nettype none
module integer_list_sorter_tb import ils_pkg::*; ();

  localparam int unsigned CAP = MAX_ITEMS_DEF;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_beat;
  logic      out_valid;
  out_beat_t out_beat;

  integer_list_sorter #(.MAX_ITEMS(CAP)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow of the list being collected, in arrival order.
  logic signed [VAL_W-1:0] pending_list[$];
  logic                    pending_dropped;
  // Sorted beats not yet seen on the output.
  out_beat_t               sorted_expect[$];
  int                      fail_count;
  bit                      gaps_on;

  // Model one accepted element; on the closing beat, queue the sorted list.
  task automatic predict_sorted(input in_beat_t b);
    logic signed [VAL_W-1:0] vals[$];
    logic signed [VAL_W-1:0] key;
    int                      j;
    out_beat_t               r;
    if (pending_list.size() < CAP) pending_list = {pending_list, b.value};
    else pending_dropped = 1'b1;
    if (!b.last_item) return;
    vals = pending_list;
    // Insertion sort; strict compare keeps equal values in arrival order.
    for (int i = 1; i < vals.size(); i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    foreach (vals[k]) begin
      r.sorted_value = vals[k];
      r.last_out     = (k == vals.size() - 1);
      r.overflow     = pending_dropped;
      sorted_expect  = {sorted_expect, r};
    end
    pending_list.delete();
    pending_dropped = 1'b0;
  endtask

  // Send one beat: optional random gap, hold start until the block takes it.
  task automatic send_element(input logic signed [VAL_W-1:0] v, input logic last);
    in_beat_t b;
    bit       took;
    b.value = v;
    b.last_item = last;
    while (gaps_on && $urandom_range(99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    took = 1'b0;
    // busy is stable in the low phase; it decides the next edge
    while (!took) begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end
    predict_sorted(b);
  endtask

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (sorted_expect.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_beat);
        fail_count++;
      end else begin
        out_beat_t e;
        e = sorted_expect.pop_front();
        if (e.sorted_value !== out_beat.sorted_value) begin
          $display("%0t: sorted_value expected %0d actual %0d", $time,
                   e.sorted_value, out_beat.sorted_value);
          fail_count++;
        end
        if (e.last_out !== out_beat.last_out) begin
          $display("%0t: last_out expected %b actual %b", $time,
                   e.last_out, out_beat.last_out);
          fail_count++;
        end
        if (e.overflow !== out_beat.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time,
                   e.overflow, out_beat.overflow);
          fail_count++;
        end
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(7))) - 4;
      default: return $signed($urandom());
    endcase
  endfunction

  // Extremes, single-element list, duplicates for stability, all-ones/zeros.
  task automatic test_directed();
    send_element(32'sh7fff_ffff, 1'b1);
    send_element(32'sh7fff_ffff, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element(32'sh0, 1'b0);
    send_element(-32'sd1, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element(32'sh5555_5555, 1'b0);
    send_element(32'shaaaa_aaaa, 1'b1);
    send_element(32'sd3, 1'b0);
    send_element(32'sd3, 1'b1);
  endtask

  // Fill the store exactly, then overrun it and close with a dropped beat.
  task automatic test_capacity();
    for (int i = 0; i < CAP; i++) send_element(rand_value(), i == CAP - 1);
    for (int i = 0; i < CAP + 3; i++) send_element(rand_value(), i == CAP + 2);
  endtask

  // Random lists: mostly short, a few long; gaps switched off for a stretch.
  task automatic test_random_lists();
    int sent;
    int len;
    sent = 0;
    while (sent < 220) begin
      gaps_on = !(sent > 60 && sent < 140);
      len = ($urandom_range(9) == 0) ? $urandom_range(CAP + 4, 40)
                                     : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) send_element(rand_value(), i == len - 1);
      sent += len;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_beat = '0;
    fail_count = 0;
    pending_dropped = 1'b0;
    gaps_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random_lists();
    start <= 1'b0;
    // Drain: the chain holds up to CAP results and the queue up to Q_DEPTH more beats.
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (2 * CAP + 20) @(posedge clk);
    if (fail_count == 0) $display("integer_list_sorter_tb: PASS");
    else $display("integer_list_sorter_tb: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("integer_list_sorter_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> integer_list_sorter.f
src/ils_pkg.sv
src/ils_front.sv
src/ils_queue.sv
src/ils_chain.sv
src/integer_list_sorter.sv
test/integer_list_sorter_tb.sv
